FILE: hw/rtl/nsdp_pkg.sv
// shared types, constants and the rate function of the container stream demultiplexer
package nsdp_pkg;

  localparam int unsigned MAX_SECTION_DEF = 32768;

  localparam logic [31:0] SYNC_FULL = 32'h4E535673;
  localparam logic [15:0] SYNC_SHORT = 16'hEFBE;
  localparam logic [31:0] CODE_NONE = 32'h454E4F4E;
  localparam logic [31:0] CODE_H264 = 32'h34363248;

  localparam logic [2:0] KIND_HEADER = 3'd1;
  localparam logic [2:0] KIND_VIDEO  = 3'd2;
  localparam logic [2:0] KIND_AUDIO  = 3'd3;
  localparam logic [2:0] KIND_AUX    = 3'd4;
  localparam logic [2:0] KIND_RESYNC = 3'd5;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_HDR     = 3'd1;
  localparam logic [2:0] PH_SHORT   = 3'd2;
  localparam logic [2:0] PH_AUXSIZE = 3'd3;
  localparam logic [2:0] PH_AUXCODE = 3'd4;
  localparam logic [2:0] PH_AUXDATA = 3'd5;
  localparam logic [2:0] PH_VIDEO   = 3'd6;
  localparam logic [2:0] PH_AUDIO   = 3'd7;

  // classified event handed from the front to the back
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload;
    logic        last;
    logic        count_slice;
    logic [63:0] hdr0;
    logic [63:0] hdr1;
    logic [31:0] chunk_code;
  } evt_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload;
    logic        last;
    logic [31:0] video_code;
    logic [31:0] audio_code;
    logic [15:0] width;
    logic [15:0] height;
    logic [18:0] rate_num;
    logic [13:0] rate_den;
    logic signed [15:0] sync_ms;
    logic [31:0] aux_code;
    logic [31:0] frame_count;
  } res_t;

  // frame rate code to numerator and denominator
  function automatic logic [32:0] rate_of(input logic [7:0] r);
    logic [4:0]  t;
    logic [18:0] n;
    logic [13:0] d;
    logic [18:0] base;
    t = r[6:2];
    n = {11'd0, r};
    d = 14'd1;
    if (r[7]) begin
      if (t < 5'd16) begin
        base = 19'd1;
        d = {9'd0, t} + 14'd1;
      end else begin
        base = {14'd0, t} - 19'd15;
      end
      unique case (r[1:0])
        2'd0: n = 19'(base * 19'd30);
        2'd1: begin
          n = 19'(base * 19'd30000);
          d = 14'(d * 14'd1001);
        end
        2'd2: n = 19'(base * 19'd25);
        default: begin
          n = 19'(base * 19'd24000);
          d = 14'(d * 14'd1001);
        end
      endcase
    end
    return {n, d};
  endfunction

endpackage

FILE: hw/rtl/nsdp_stream_if.sv
// valid/ready stream interface
interface nsdp_stream_if #(parameter type T = logic [7:0]);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/nsdp_front.sv
// byte parser: tracks the container layout and classifies each byte
module nsdp_front #(
  parameter int unsigned MAX_SECTION = nsdp_pkg::MAX_SECTION_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  output logic                evt_valid,
  input  logic                evt_ready,
  output nsdp_pkg::evt_t      evt_data
);
  logic [31:0] sync_r, sync_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [63:0] hdr0_r, hdr0_nxt, hdr1_r, hdr1_nxt;
  logic [3:0]  aux_r, aux_nxt;
  logic [19:0] vid_r, vid_nxt;
  logic [15:0] aud_r, aud_nxt;
  logic [15:0] chk_r, chk_nxt;
  logic        need_r, need_nxt;
  logic [31:0] code_r, code_nxt;
  logic        fire, emit;
  nsdp_pkg::evt_t ev;
  logic [31:0] sh;
  logic [15:0] csize;
  logic [20:0] cost;
  logic [19:0] aud_full;

  assign in_ready = evt_ready;
  assign fire = in_valid && in_ready;
  assign sh = {sync_r[23:0], in_data_byte};
  assign csize = {in_data_byte, chk_r[7:0]};
  assign cost = 21'd6 + {5'd0, chk_r};
  assign aud_full = {4'd0, in_data_byte, aud_r[7:0]};

  function automatic logic passes(input logic ns, input logic [31:0] c);
    return !ns && c != 32'd0 && c != nsdp_pkg::CODE_NONE;
  endfunction

  always_comb begin
    logic [2:0] sec;
    logic [19:0] v1;
    logic [15:0] a1, c1;
    sync_nxt = sync_r; phase_nxt = phase_r; idx_nxt = idx_r;
    hdr0_nxt = hdr0_r; hdr1_nxt = hdr1_r; aux_nxt = aux_r; vid_nxt = vid_r;
    aud_nxt = aud_r; chk_nxt = chk_r; need_nxt = need_r; code_nxt = code_r;
    emit = 1'b0;
    ev = '0;
    sec = nsdp_pkg::PH_HUNT;
    v1 = vid_r; a1 = aud_r; c1 = chk_r;
    unique case (phase_r)
      nsdp_pkg::PH_HUNT: begin
        sync_nxt = sh;
        if (sh == nsdp_pkg::SYNC_FULL) begin
          phase_nxt = nsdp_pkg::PH_HDR; idx_nxt = 5'd0;
        end else if (sh[15:0] == nsdp_pkg::SYNC_SHORT) begin
          phase_nxt = nsdp_pkg::PH_SHORT; idx_nxt = 5'd15;
        end
      end
      nsdp_pkg::PH_HDR, nsdp_pkg::PH_SHORT: begin
        idx_nxt = idx_r + 5'd1;
        if (idx_r < 5'd8) hdr0_nxt[idx_r[2:0]*8 +: 8] = in_data_byte;
        else if (idx_r < 5'd15) hdr1_nxt[idx_r[2:0]*8 +: 8] = in_data_byte;
        else if (idx_r == 5'd15) begin
          aux_nxt = in_data_byte[3:0]; vid_nxt = {16'd0, in_data_byte[7:4]};
        end else if (idx_r == 5'd16) vid_nxt = vid_r | {8'd0, in_data_byte, 4'd0};
        else if (idx_r == 5'd17) vid_nxt = vid_r | {in_data_byte, 12'd0};
        else if (idx_r == 5'd18) aud_nxt = {8'd0, in_data_byte};
        else begin
          aud_nxt = aud_full[15:0];
          sync_nxt = '0; idx_nxt = 5'd0; emit = 1'b1;
          if (vid_r > 20'(MAX_SECTION)) begin
            aux_nxt = '0; vid_nxt = '0; aud_nxt = '0; chk_nxt = '0;
            phase_nxt = nsdp_pkg::PH_HUNT;
            ev.kind = nsdp_pkg::KIND_RESYNC;
          end else begin
            if (phase_r == nsdp_pkg::PH_HDR && (vid_r != 20'd0 || aud_full != 20'd0))
              need_nxt = 1'b0;
            if (aux_r != 4'd0) phase_nxt = nsdp_pkg::PH_AUXSIZE;
            else if (vid_r != 20'd0) phase_nxt = nsdp_pkg::PH_VIDEO;
            else if (aud_full != 20'd0) phase_nxt = nsdp_pkg::PH_AUDIO;
            else phase_nxt = nsdp_pkg::PH_HUNT;
            ev.kind = nsdp_pkg::KIND_HEADER;
          end
        end
      end
      nsdp_pkg::PH_AUXSIZE: begin
        if (idx_r == 5'd0) begin
          chk_nxt = {8'd0, in_data_byte}; idx_nxt = 5'd1;
        end else begin
          chk_nxt = csize;
          if (csize > 16'(MAX_SECTION)) begin
            aux_nxt = '0; vid_nxt = '0; aud_nxt = '0; chk_nxt = '0; sync_nxt = '0;
            phase_nxt = nsdp_pkg::PH_HUNT; idx_nxt = 5'd0; emit = 1'b1;
            ev.kind = nsdp_pkg::KIND_RESYNC;
          end else begin
            code_nxt = '0; phase_nxt = nsdp_pkg::PH_AUXCODE; idx_nxt = 5'd0;
          end
        end
      end
      nsdp_pkg::PH_AUXCODE: begin
        code_nxt[idx_r[1:0]*8 +: 8] = in_data_byte;
        if (idx_r < 5'd3) idx_nxt = idx_r + 5'd1;
        else begin
          v1 = ({1'b0, vid_r} > cost) ? 20'({1'b0, vid_r} - cost) : 20'd0;
          vid_nxt = v1;
          aux_nxt = (aux_r != 4'd0) ? aux_r - 4'd1 : 4'd0;
          idx_nxt = 5'd0;
          if (chk_r == 16'd0) begin
            if (aux_nxt != 4'd0) phase_nxt = nsdp_pkg::PH_AUXSIZE;
            else if (v1 != 20'd0) phase_nxt = nsdp_pkg::PH_VIDEO;
            else if (aud_r != 16'd0) phase_nxt = nsdp_pkg::PH_AUDIO;
            else phase_nxt = nsdp_pkg::PH_HUNT;
          end else phase_nxt = nsdp_pkg::PH_AUXDATA;
        end
      end
      nsdp_pkg::PH_AUXDATA, nsdp_pkg::PH_VIDEO, nsdp_pkg::PH_AUDIO: begin
        if (phase_r == nsdp_pkg::PH_AUXDATA) begin
          c1 = (chk_r != 16'd0) ? chk_r - 16'd1 : 16'd0;
          chk_nxt = c1;
          ev.last = (c1 == 16'd0);
          ev.kind = nsdp_pkg::KIND_AUX;
          emit = passes(need_r, code_r);
        end else if (phase_r == nsdp_pkg::PH_VIDEO) begin
          v1 = (vid_r != 20'd0) ? vid_r - 20'd1 : 20'd0;
          vid_nxt = v1;
          ev.last = (v1 == 20'd0);
          ev.kind = nsdp_pkg::KIND_VIDEO;
          emit = passes(need_r, hdr0_r[31:0]);
          ev.count_slice = hdr0_r[31:0] == nsdp_pkg::CODE_H264;
        end else begin
          a1 = (aud_r != 16'd0) ? aud_r - 16'd1 : 16'd0;
          aud_nxt = a1;
          ev.last = (a1 == 16'd0);
          ev.kind = nsdp_pkg::KIND_AUDIO;
          emit = passes(need_r, hdr0_r[63:32]);
        end
        if (ev.last) begin
          if (aux_r != 4'd0) sec = nsdp_pkg::PH_AUXSIZE;
          else if (v1 != 20'd0) sec = nsdp_pkg::PH_VIDEO;
          else if (a1 != 16'd0) sec = nsdp_pkg::PH_AUDIO;
          phase_nxt = sec; idx_nxt = 5'd0;
        end
        ev.payload = in_data_byte;
      end
      default: phase_nxt = nsdp_pkg::PH_HUNT;
    endcase
    ev.hdr0 = hdr0_nxt;
    ev.hdr1 = hdr1_nxt;
    ev.chunk_code = code_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= '0; phase_r <= nsdp_pkg::PH_HUNT; idx_r <= '0;
      hdr0_r <= '0; hdr1_r <= '0; aux_r <= '0; vid_r <= '0; aud_r <= '0;
      chk_r <= '0; need_r <= 1'b1; code_r <= '0; evt_valid <= 1'b0;
    end else begin
      if (evt_ready) evt_valid <= fire && emit;
      if (fire) begin
        sync_r <= sync_nxt; phase_r <= phase_nxt; idx_r <= idx_nxt;
        hdr0_r <= hdr0_nxt; hdr1_r <= hdr1_nxt; aux_r <= aux_nxt;
        vid_r <= vid_nxt; aud_r <= aud_nxt; chk_r <= chk_nxt;
        need_r <= need_nxt; code_r <= code_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit && evt_ready) evt_data <= ev;
  end
endmodule

FILE: hw/rtl/nsdp_back.sv
// result builder: slice counting, rate decode and output register
module nsdp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                evt_valid,
  output logic                evt_ready,
  input  nsdp_pkg::evt_t      evt_data,
  output logic                res_valid,
  input  logic                res_ready,
  output nsdp_pkg::res_t      res_data
);
  logic [39:0] hist_r, hist_nxt;
  logic [31:0] frames_r, frames_nxt;
  logic [32:0] rate;
  logic        take;

  assign evt_ready = !res_valid || res_ready;
  assign take = evt_valid && evt_ready;
  assign rate = nsdp_pkg::rate_of(evt_data.hdr1[39:32]);

  always_comb begin
    hist_nxt = hist_r;
    frames_nxt = frames_r;
    if (evt_data.count_slice) begin
      hist_nxt = {hist_r[31:0], evt_data.payload};
      if (hist_nxt[39:16] == 24'd1 && (hist_nxt[12:8] == 5'd1 || hist_nxt[12:8] == 5'd5)
          && hist_nxt[7])
        frames_nxt = frames_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0; frames_r <= '0; res_valid <= 1'b0;
    end else begin
      if (evt_ready) res_valid <= evt_valid;
      if (take) begin
        hist_r <= hist_nxt; frames_r <= frames_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_data.kind <= evt_data.kind;
      res_data.payload <= evt_data.payload;
      res_data.last <= evt_data.last;
      res_data.video_code <= evt_data.hdr0[31:0];
      res_data.audio_code <= evt_data.hdr0[63:32];
      res_data.width <= evt_data.hdr1[15:0];
      res_data.height <= evt_data.hdr1[31:16];
      res_data.rate_num <= rate[32:14];
      res_data.rate_den <= rate[13:0];
      res_data.sync_ms <= evt_data.hdr1[55:40];
      res_data.aux_code <= evt_data.chunk_code;
      res_data.frame_count <= frames_nxt;
    end
  end
endmodule

FILE: hw/rtl/nsv_stream_demux_parser_top.sv
// top level of the container stream demultiplexer
// One byte enters per clock while the output is not stalled: the front parses the byte and
// writes at most one classified transaction into a one-entry event register, the back
// adds the slice count and rate decode and holds the result in an output register.
// Each byte's result passes both registers in turn; a stalled output stalls input.
module nsv_stream_demux_parser_top #(
  parameter int unsigned MAX_SECTION = nsdp_pkg::MAX_SECTION_DEF
) (
  input  logic clk,
  input  logic rst_n,
  nsdp_stream_if.sink   in_ch,
  nsdp_stream_if.source out_ch
);
  logic           evt_valid, evt_ready;
  nsdp_pkg::evt_t evt_data;

  // front: header/section tracking
  nsdp_front #(.MAX_SECTION(MAX_SECTION)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data_byte(in_ch.data),
    .evt_valid, .evt_ready, .evt_data
  );

  // back: result assembly
  nsdp_back u_back (
    .clk, .rst_n,
    .evt_valid, .evt_ready, .evt_data,
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res_data(out_ch.data)
  );
endmodule

FILE: hw/rtl/nsdp_checker.sv
// port-level assertions for the demultiplexer top
module nsdp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] out_kind
);
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind >= nsdp_pkg::KIND_HEADER && out_kind <= nsdp_pkg::KIND_RESYNC))
    else $error("bad kind");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("valid in reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("input taken while stalled");
endmodule

bind nsv_stream_demux_parser_top nsdp_checker u_chk (
  .clk, .rst_n, .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.data.kind)
);

FILE: tb/testbench.sv
// testbench for the container stream demultiplexer: table-driven directed bytes, then random streams
`timescale 1ns / 1ps
module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nsdp_stream_if #(.T(logic [7:0]))     in_ch ();
  nsdp_stream_if #(.T(nsdp_pkg::res_t)) out_ch ();

  nsv_stream_demux_parser_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // predictor state, a private copy of what the parser tracks
  // ---------------------------------------------------------------
  logic [31:0] win;
  logic [2:0]  ph;
  logic [4:0]  idx;
  logic [63:0] hdr [2];
  logic [3:0]  aux_cnt;
  logic [19:0] vid_cnt;
  logic [15:0] aud_cnt;
  logic [15:0] chk_cnt;
  logic        locked_out;
  logic [39:0] nal_hist;
  logic [31:0] slices;
  logic [31:0] chk_code;

  nsdp_pkg::res_t parsed_q[$];
  // expected value typed by hand for directed rows, checked on the kind only
  logic [2:0] hand_kind_q[$];
  logic       hand_valid_q[$];

  int mismatches = 0;
  int results_seen = 0;
  int headers_seen = 0;
  int resyncs_seen = 0;
  int bytes_sent = 0;

  function automatic nsdp_pkg::res_t pack_result(logic [2:0] k, logic [7:0] b, logic l);
    nsdp_pkg::res_t r;
    logic [7:0]  code;
    logic [4:0]  t;
    logic [18:0] n;
    logic [13:0] d;
    logic [18:0] base;
    code = hdr[1][39:32];
    t = code[6:2];
    n = {11'd0, code};
    d = 14'd1;
    if (code[7]) begin
      if (t < 5'd16) begin
        base = 19'd1;
        d = 14'(t) + 14'd1;
      end else begin
        base = 19'(t) - 19'd15;
      end
      case (code[1:0])
        2'd0: n = 19'(base * 30);
        2'd1: begin
          n = 19'(base * 30000);
          d = 14'(d * 1001);
        end
        2'd2: n = 19'(base * 25);
        default: begin
          n = 19'(base * 24000);
          d = 14'(d * 1001);
        end
      endcase
    end
    r.kind = k;
    r.payload = b;
    r.last = l;
    r.video_code = hdr[0][31:0];
    r.audio_code = hdr[0][63:32];
    r.width = hdr[1][15:0];
    r.height = hdr[1][31:16];
    r.rate_num = n;
    r.rate_den = d;
    r.sync_ms = hdr[1][55:40];
    r.aux_code = chk_code;
    r.frame_count = slices;
    return r;
  endfunction

  task automatic reset_parser();
    win = '0; ph = nsdp_pkg::PH_HUNT; idx = '0;
    hdr[0] = '0; hdr[1] = '0;
    aux_cnt = '0; vid_cnt = '0; aud_cnt = '0; chk_cnt = '0;
    locked_out = 1'b1; nal_hist = '0; slices = '0; chk_code = '0;
  endtask

  task automatic drop_sections();
    aux_cnt = '0; vid_cnt = '0; aud_cnt = '0; chk_cnt = '0;
    win = '0; ph = nsdp_pkg::PH_HUNT; idx = '0;
  endtask

  task automatic advance_section();
    idx = '0;
    if (aux_cnt != 0) ph = nsdp_pkg::PH_AUXSIZE;
    else if (vid_cnt != 0) ph = nsdp_pkg::PH_VIDEO;
    else if (aud_cnt != 0) ph = nsdp_pkg::PH_AUDIO;
    else ph = nsdp_pkg::PH_HUNT;
  endtask

  function automatic logic code_passes(logic [31:0] c);
    return !locked_out && c != 32'd0 && c != nsdp_pkg::CODE_NONE;
  endfunction

  // step the parser model by one byte; returns 1 with a result in r when one is due
  task automatic parse_byte(input logic [7:0] b, output logic got, output nsdp_pkg::res_t r);
    int unsigned cost;
    logic fin;
    logic [39:0] v;
    got = 1'b0;
    r = '0;
    case (ph)
      nsdp_pkg::PH_HUNT: begin
        win = {win[23:0], b};
        if (win == nsdp_pkg::SYNC_FULL) begin
          ph = nsdp_pkg::PH_HDR; idx = '0;
        end else if (win[15:0] == nsdp_pkg::SYNC_SHORT) begin
          ph = nsdp_pkg::PH_SHORT; idx = 5'd15;
        end
      end
      nsdp_pkg::PH_HDR, nsdp_pkg::PH_SHORT: begin
        if (idx < 15) begin
          hdr[idx >= 8][8*idx[2:0] +: 8] = b;
          idx++;
        end else if (idx == 15) begin
          aux_cnt = b[3:0]; vid_cnt = {16'd0, b[7:4]}; idx++;
        end else if (idx == 16) begin
          vid_cnt[11:4] = b; idx++;
        end else if (idx == 17) begin
          vid_cnt[19:12] = b; idx++;
        end else if (idx == 18) begin
          aud_cnt = {8'd0, b}; idx++;
        end else begin
          aud_cnt[15:8] = b;
          win = '0;
          if (vid_cnt > 32768) begin
            drop_sections();
            got = 1'b1; r = pack_result(nsdp_pkg::KIND_RESYNC, 8'd0, 1'b0);
          end else begin
            if (ph == nsdp_pkg::PH_HDR && (vid_cnt != 0 || aud_cnt != 0)) locked_out = 1'b0;
            advance_section();
            got = 1'b1; r = pack_result(nsdp_pkg::KIND_HEADER, 8'd0, 1'b0);
          end
        end
      end
      nsdp_pkg::PH_AUXSIZE: begin
        if (idx == 0) begin
          chk_cnt = {8'd0, b}; idx = 5'd1;
        end else begin
          chk_cnt[15:8] = b;
          if (chk_cnt > 32768) begin
            drop_sections();
            got = 1'b1; r = pack_result(nsdp_pkg::KIND_RESYNC, 8'd0, 1'b0);
          end else begin
            chk_code = '0; ph = nsdp_pkg::PH_AUXCODE; idx = '0;
          end
        end
      end
      nsdp_pkg::PH_AUXCODE: begin
        chk_code[8*idx[1:0] +: 8] = b;
        if (idx < 3) begin
          idx++;
        end else begin
          cost = 6 + chk_cnt;
          vid_cnt = (vid_cnt > cost) ? 20'(vid_cnt - cost) : 20'd0;
          if (aux_cnt != 0) aux_cnt--;
          if (chk_cnt == 0) advance_section();
          else begin
            ph = nsdp_pkg::PH_AUXDATA; idx = '0;
          end
        end
      end
      nsdp_pkg::PH_AUXDATA: begin
        if (chk_cnt != 0) chk_cnt--;
        fin = chk_cnt == 0;
        if (fin) advance_section();
        if (code_passes(chk_code)) begin
          got = 1'b1; r = pack_result(nsdp_pkg::KIND_AUX, b, fin);
        end
      end
      nsdp_pkg::PH_VIDEO: begin
        if (vid_cnt != 0) vid_cnt--;
        fin = vid_cnt == 0;
        if (fin) advance_section();
        if (code_passes(hdr[0][31:0])) begin
          if (hdr[0][31:0] == nsdp_pkg::CODE_H264) begin
            v = {nal_hist[31:0], b};
            nal_hist = v;
            if (v[39:16] == 24'd1 && (v[12:8] == 5'd1 || v[12:8] == 5'd5) && v[7])
              slices++;
          end
          got = 1'b1; r = pack_result(nsdp_pkg::KIND_VIDEO, b, fin);
        end
      end
      default: begin
        if (aud_cnt != 0) aud_cnt--;
        fin = aud_cnt == 0;
        if (fin) advance_section();
        if (code_passes(hdr[0][63:32])) begin
          got = 1'b1; r = pack_result(nsdp_pkg::KIND_AUDIO, b, fin);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------
  // stimulus storage: every byte to send, with an optional hand kind
  // ---------------------------------------------------------------
  logic [7:0] stim_q[$];
  logic       stim_hand_q[$];
  logic [2:0] stim_kind_q[$];

  task automatic push_byte(logic [7:0] b);
    stim_q.push_back(b); stim_hand_q.push_back(1'b0); stim_kind_q.push_back('0);
  endtask

  task automatic push_u32(logic [31:0] w);
    for (int i = 0; i < 4; i++) push_byte(w[8*i +: 8]);
  endtask

  // full header: sync, codes, geometry, rate, sync offset, sizes
  task automatic push_full(logic [31:0] vc, logic [31:0] ac, logic [15:0] w, logic [15:0] h,
                           logic [7:0] rate, logic [15:0] ms, logic [3:0] naux,
                           logic [19:0] vsz, logic [15:0] asz);
    push_u32({8'h73, 8'h56, 8'h53, 8'h4E});
    push_u32(vc); push_u32(ac);
    push_byte(w[7:0]); push_byte(w[15:8]); push_byte(h[7:0]); push_byte(h[15:8]);
    push_byte(rate); push_byte(ms[7:0]); push_byte(ms[15:8]);
    push_byte({vsz[3:0], naux}); push_byte(vsz[11:4]); push_byte(vsz[19:12]);
    push_byte(asz[7:0]); push_byte(asz[15:8]);
  endtask

  task automatic push_short(logic [3:0] naux, logic [19:0] vsz, logic [15:0] asz);
    push_byte(8'hEF); push_byte(8'hBE);
    push_byte({vsz[3:0], naux}); push_byte(vsz[11:4]); push_byte(vsz[19:12]);
    push_byte(asz[7:0]); push_byte(asz[15:8]);
  endtask

  function automatic logic [31:0] pick_code();
    case ($urandom_range(0, 5))
      0: return nsdp_pkg::CODE_H264;
      1: return nsdp_pkg::CODE_NONE;
      2: return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  // one random well-formed packet with aux chunks, video and audio payload
  task automatic push_packet(logic full);
    int naux, vsz, asz, csz[4];
    logic [31:0] vc;
    naux = $urandom_range(0, 2);
    asz = $urandom_range(0, 12);
    vsz = 0;
    for (int i = 0; i < naux; i++) begin
      csz[i] = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      vsz += 6 + csz[i];
    end
    vsz += $urandom_range(0, 16);
    vc = pick_code();
    if (full)
      push_full(vc, pick_code(), 16'($urandom()), 16'($urandom()), 8'($urandom()),
                16'($urandom()), 4'(naux), 20'(vsz), 16'(asz));
    else
      push_short(4'(naux), 20'(vsz), 16'(asz));
    for (int i = 0; i < naux; i++) begin
      push_byte(8'(csz[i])); push_byte(8'(csz[i] >> 8));
      push_u32(($urandom_range(0, 3) == 0) ? nsdp_pkg::CODE_NONE : $urandom());
      for (int j = 0; j < csz[i]; j++) push_byte(8'($urandom()));
    end
    for (int i = 0; i < vsz - 0; i++) begin
      // sprinkle slice starts into the video bytes
      if ($urandom_range(0, 7) == 0 && i + 5 <= vsz) begin
        push_byte(8'h00); push_byte(8'h00); push_byte(8'h01);
        push_byte($urandom_range(0, 1) ? 8'h65 : 8'h21);
        push_byte(8'h80 | 8'($urandom()));
        i += 4;
      end else begin
        push_byte(8'($urandom()));
      end
    end
    for (int i = 0; i < asz; i++) push_byte(8'($urandom()));
  endtask

  // ---------------------------------------------------------------
  // directed table: a few rows carry the kind read straight off the spec
  // ---------------------------------------------------------------
  typedef struct {
    logic [7:0] b;
    logic       hand;
    logic [2:0] kind;
  } row_t;

  row_t dir_tab[] = '{
    // short header before any full one: payload stays suppressed
    '{8'hEF, 0, 0}, '{8'hBE, 0, 0}, '{8'h20, 0, 0}, '{8'h00, 0, 0}, '{8'h00, 0, 0},
    '{8'h00, 0, 0}, '{8'h00, 1, nsdp_pkg::KIND_HEADER},
    '{8'hAA, 0, 0}, '{8'h55, 0, 0},
    // oversize video size in a short header
    '{8'hEF, 0, 0}, '{8'hBE, 0, 0}, '{8'h10, 0, 0}, '{8'h00, 0, 0}, '{8'h08, 0, 0},
    '{8'hFF, 0, 0}, '{8'hFF, 1, nsdp_pkg::KIND_RESYNC},
    // extremes of the byte
    '{8'h00, 0, 0}, '{8'hFF, 0, 0}
  };

  task automatic build_stimulus();
    foreach (dir_tab[i]) begin
      stim_q.push_back(dir_tab[i].b);
      stim_hand_q.push_back(dir_tab[i].hand);
      stim_kind_q.push_back(dir_tab[i].kind);
    end
    // full H.264 header with extreme fields and one aux chunk with oversize size
    push_full(nsdp_pkg::CODE_H264, 32'h3350_4D41, 16'hFFFF, 16'h0000, 8'hFF, 16'h8000,
              4'd1, 20'd20, 16'd0);
    push_byte(8'h01); push_byte(8'h80);
    // full header, empty aux chunk, video with a slice start, audio
    push_full(nsdp_pkg::CODE_H264, 32'h3350_4D41, 16'd640, 16'd480, 8'h81, 16'h7FFF,
              4'd1, 20'd12, 16'd2);
    push_byte(8'h00); push_byte(8'h00); push_u32(32'h4154_5841);
    push_byte(8'h00); push_byte(8'h00); push_byte(8'h01); push_byte(8'h25);
    push_byte(8'h88); push_byte(8'h11);
    push_byte(8'h01); push_byte(8'hFE);
  endtask

  // ---------------------------------------------------------------
  // sender: one byte per transaction with random gaps
  // ---------------------------------------------------------------
  logic pause_req = 1'b0;
  logic send_done = 1'b0;

  initial begin
    logic got;
    nsdp_pkg::res_t r;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    reset_parser();
    build_stimulus();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (stim_q.size() != 0) begin
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (bytes_sent > 300 && bytes_sent < 330) gap = 0;
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // one pause that drains every expected result
      if (pause_req) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (parsed_q.size() != 0) @(posedge clk);
        pause_req = 1'b0;
      end
      in_ch.valid <= 1'b1;
      in_ch.data  <= stim_q[0];
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      // transaction accepted at this edge: predict its result
      parse_byte(stim_q[0], got, r);
      if (got) begin
        parsed_q.push_back(r);
        hand_valid_q.push_back(stim_hand_q[0]);
        hand_kind_q.push_back(stim_kind_q[0]);
      end else if (stim_hand_q[0]) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d should give a result", bytes_sent);
      end
      void'(stim_q.pop_front());
      void'(stim_hand_q.pop_front());
      void'(stim_kind_q.pop_front());
      bytes_sent++;
      if (bytes_sent == 150) pause_req = 1'b1;
      // refill with random packets and some noise
      if (stim_q.size() == 0 && bytes_sent < 550) begin
        case ($urandom_range(0, 9))
          0: for (int i = 0; i < 6; i++) push_byte(8'($urandom()));
          1: push_short(4'($urandom()), 20'($urandom()), 16'($urandom_range(0, 3)));
          2, 3: push_packet(1'b0);
          default: push_packet(1'b1);
        endcase
      end
    end
    in_ch.valid <= 1'b0;
    send_done = 1'b1;
  end

  // ---------------------------------------------------------------
  // receiver: random stalls, one long hold-off and one always-ready window, counted in cycles
  // ---------------------------------------------------------------
  int rx_cycle = 0;
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle > 700 && rx_cycle < 760) out_ch.ready <= 1'b0;
      else if (rx_cycle > 2000 && rx_cycle < 2300) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 4) != 0);
    end
  end

  // checker: compares every accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      nsdp_pkg::res_t want;
      results_seen++;
      if (parsed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
      end else begin
        want = parsed_q.pop_front();
        if (hand_valid_q.pop_front() && hand_kind_q[0] != out_ch.data.kind) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed kind: expected %0d got %0d", hand_kind_q[0], out_ch.data.kind);
        end
        void'(hand_kind_q.pop_front());
        if (want.kind == nsdp_pkg::KIND_HEADER) headers_seen++;
        if (want.kind == nsdp_pkg::KIND_RESYNC) resyncs_seen++;
        if (out_ch.data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d: expected %p got %p",
                                         results_seen, want, out_ch.data);
        end
      end
    end
  end

  // end of run
  initial begin
    wait (send_done);
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (parsed_q.size() != 0) mismatches++;
    $display("sent %0d bytes, checked %0d results (%0d headers, %0d resyncs)",
             bytes_sent, results_seen, headers_seen, resyncs_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/nsdp_pkg.sv
hw/rtl/nsdp_stream_if.sv
hw/rtl/nsdp_front.sv
hw/rtl/nsdp_back.sv
hw/rtl/nsv_stream_demux_parser_top.sv
hw/rtl/nsdp_checker.sv
tb/testbench.sv
